// ===== sv/kmd_pkg.sv =====
// ----------------------------------------------------------------------------
// kmd_pkg: shared types and constants for the keypad matrix debouncer
// Holds the key character map, the stream payload widths and the lane
// result type passed from the per-key lanes to the merge stage.
// ----------------------------------------------------------------------------
package kmd_pkg;

    // payload widths
    localparam int TIME_W     = 32;
    localparam int RAW_W      = 12;
    localparam int CHAR_W     = 7;
    localparam int DEB_W      = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    // key map size and characters, row by row
    localparam int MAP_ROWS = 4;
    localparam int MAP_COLS = 3;

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'h3F;

    localparam logic [CHAR_W-1:0] KEY_MAP [MAP_ROWS][MAP_COLS] = '{
        '{7'h4E, 7'h23, 7'h2A},
        '{7'h37, 7'h38, 7'h39},
        '{7'h34, 7'h35, 7'h36},
        '{7'h31, 7'h32, 7'h33}
    };

    // what one lane reports for the current request
    typedef struct packed {
        logic stable;
        logic changed;
    } lane_res_t;

    // character of the key at row r, column c; unmapped keys read as '?'
    function automatic logic [CHAR_W-1:0] key_char(input int r, input int c);
        logic [CHAR_W-1:0] ch;
        ch = CHAR_UNKNOWN;
        if (r < MAP_ROWS && c < MAP_COLS)
        begin
            ch = KEY_MAP[r[1:0]][c[1:0]];
        end
        return ch;
    endfunction

endpackage

// ===== sv/kmd_lane.sv =====
// ----------------------------------------------------------------------------
// kmd_lane: debounce state of one key
// Tracks the raw level, the time of its last change and the stable level,
// and reports the new stable level and whether it changed on this request.
// ----------------------------------------------------------------------------
module kmd_lane (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       upd,
    input  logic [kmd_pkg::TIME_W-1:0] now_ms,
    input  logic                       raw_bit,
    input  logic [kmd_pkg::DEB_W-1:0]  debounce_ms,
    output kmd_pkg::lane_res_t         res
);
    import kmd_pkg::*;

    logic              raw_level_reg;
    logic              stable_level_reg;
    logic [TIME_W-1:0] change_time_reg;
    logic              raw_level_next;
    logic              stable_level_next;
    logic [TIME_W-1:0] change_time_next;

    logic              raw_chg;
    logic [TIME_W-1:0] elapsed;
    logic              settled;

    // elapsed time since the last raw change, wrapping at 2^32
    always_comb
    begin
        raw_chg = raw_bit != raw_level_reg;
        elapsed = now_ms - change_time_reg;
        if (raw_chg)
        begin
            settled = debounce_ms == '0;
        end
        else
        begin
            settled = elapsed >= {{(TIME_W-DEB_W){1'b0}}, debounce_ms};
        end
    end

    // next state of the key
    always_comb
    begin
        raw_level_next    = raw_bit;
        change_time_next  = raw_chg ? now_ms : change_time_reg;
        stable_level_next = settled ? raw_bit : stable_level_reg;
        res.stable        = stable_level_next;
        res.changed       = settled && (stable_level_reg != raw_bit);
    end

    // key state registers, updated on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_level_reg    <= 1'b0;
            stable_level_reg <= 1'b0;
            change_time_reg  <= '0;
        end
        else if (upd)
        begin
            raw_level_reg    <= raw_level_next;
            stable_level_reg <= stable_level_next;
            change_time_reg  <= change_time_next;
        end
    end

endmodule

// ===== sv/kmd_merge.sv =====
// ----------------------------------------------------------------------------
// kmd_merge: combines the lane results of one scan
// Forms the changed flag, the visible stable vector and the new last key
// (character of the highest-index stable pressed key when anything changed).
// ----------------------------------------------------------------------------
module kmd_merge #(
    parameter int ROWS = 4,
    parameter int COLS = 3
) (
    input  kmd_pkg::lane_res_t         lanes [ROWS*COLS],
    input  logic [kmd_pkg::CHAR_W-1:0] last_key,
    output logic                       any_changed,
    output logic [kmd_pkg::RAW_W-1:0]  stable_pressed,
    output logic [kmd_pkg::CHAR_W-1:0] last_key_next
);
    import kmd_pkg::*;

    localparam int NKEYS = ROWS * COLS;

    logic [CHAR_W-1:0] chars [NKEYS];
    logic              hit;
    logic [CHAR_W-1:0] pick;

    // constant character for each key
    for (genvar k = 0; k < NKEYS; k++)
    begin : g_char
        localparam logic [CHAR_W-1:0] KC = key_char(k / COLS, k % COLS);
        assign chars[k] = KC;
    end

    // changed flag, last stable pressed key and visible stable bits
    always_comb
    begin
        any_changed    = 1'b0;
        hit            = 1'b0;
        pick           = CHAR_SPACE;
        stable_pressed = '0;
        for (int k = 0; k < NKEYS; k++)
        begin
            any_changed = any_changed | lanes[k].changed;
            if (lanes[k].stable)
            begin
                hit  = 1'b1;
                pick = chars[k];
            end
        end
        for (int k = 0; k < RAW_W; k++)
        begin
            if (k < NKEYS)
            begin
                stable_pressed[k] = lanes[k].stable;
            end
        end
        last_key_next = (any_changed && hit) ? pick : last_key;
    end

endmodule

// ===== sv/keypad_matrix_debouncer.sv =====
// ----------------------------------------------------------------------------
// keypad_matrix_debouncer: debouncer for a scanned key matrix
// Each request on the input stream is one full scan of the matrix. The block
// debounces every key against the millisecond time stamp and returns one
// result per scan: changed flag, debounced key vector and last key character.
//
// Usage:
//   s_* stream: s_tdata = {raw_pressed, now_ms}, one scan per request.
//   m_* stream: m_tdata = {last_key_char, stable_pressed, any_changed}.
//   cfg channel: cfg_data writes debounce_ms; cfg_ready is always high.
//   Write it only while no scan is in flight.
//   A result is registered in the output register (skid register on a stall).
//   Throughput: one scan per cycle unless stalled. Every key has its own
//   lane (32-bit subtract and compare); one merge stage picks the last pressed key.
//   Stall: an output register plus one skid register; s_tready drops only
//   when both hold a result, so two scans may wait on a stalled receiver.
//   Reset: all keys released, change times zero, last key a space,
//   debounce_ms = 5, output stream empty.
// ----------------------------------------------------------------------------
module keypad_matrix_debouncer #(
    parameter int ROWS = 4,
    parameter int COLS = 3
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // fields from bit 0: now_ms[31:0], raw_pressed[43:32], zero pad
    input  logic [kmd_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // fields from bit 0: any_changed[0], stable_pressed[12:1],
    // last_key_char[19:13], zero pad
    output logic [kmd_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kmd_pkg::DEB_W-1:0]      cfg_data
);
    import kmd_pkg::*;

    localparam int NKEYS = ROWS * COLS;
    localparam int RES_W = 1 + RAW_W + CHAR_W;

    logic [DEB_W-1:0]  debounce_reg;
    logic [CHAR_W-1:0] last_key_reg;
    logic [CHAR_W-1:0] last_key_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [RES_W-1:0]  out_data_reg;
    logic [RES_W-1:0]  out_data_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    logic [RES_W-1:0]  skid_data_reg;
    logic [RES_W-1:0]  skid_data_next;

    logic [TIME_W-1:0] now_ms;
    logic [RAW_W-1:0]  raw_pressed;
    logic              in_fire;
    logic              out_fire;
    lane_res_t         lanes [NKEYS];
    logic              any_changed;
    logic [RAW_W-1:0]  stable_pressed;
    logic [RES_W-1:0]  result;

    // unpack input request
    assign now_ms      = s_tdata[TIME_W-1:0];
    assign raw_pressed = s_tdata[TIME_W+RAW_W-1:TIME_W];

    assign s_tready  = !skid_valid_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = out_valid_reg && m_tready;
    assign cfg_ready = 1'b1;

    // one lane per key; keys beyond the raw field never see a press
    for (genvar k = 0; k < NKEYS; k++)
    begin : g_lane
        logic raw_bit;
        if (k < RAW_W)
        begin : g_raw
            assign raw_bit = raw_pressed[k];
        end
        else
        begin : g_none
            assign raw_bit = 1'b0;
        end

        kmd_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .upd         (in_fire),
            .now_ms      (now_ms),
            .raw_bit     (raw_bit),
            .debounce_ms (debounce_reg),
            .res         (lanes[k])
        );
    end

    // merge of lane results
    kmd_merge #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_merge (
        .lanes          (lanes),
        .last_key       (last_key_reg),
        .any_changed    (any_changed),
        .stable_pressed (stable_pressed),
        .last_key_next  (last_key_next)
    );

    assign result = {last_key_next, stable_pressed, any_changed};

    // output register with skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_fire;
                out_data_next  = result;
            end
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            debounce_reg   <= 16'd5;
            last_key_reg   <= CHAR_SPACE;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                debounce_reg <= cfg_data;
            end
            if (in_fire)
            begin
                last_key_reg <= last_key_next;
            end
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-RES_W){1'b0}}, out_data_reg};

endmodule

// ===== sv/kmd_checker.sv =====
// ----------------------------------------------------------------------------
// kmd_checker: port-level checks for the keypad matrix debouncer
// Watches the stream and configuration ports of the top level over time.
// ----------------------------------------------------------------------------
module kmd_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [kmd_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready
);

    // stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // input back-pressure only when a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // an accepted scan is followed next cycle by a valid result on the output
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted scan produced no result");

    // configuration is always taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind keypad_matrix_debouncer kmd_checker u_kmd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
